// ----- hdl/idv_pkg.sv -----
package idv_pkg;

	// fixed width of every data port
	localparam int PORT_W = 64;

	// queue between classifier and divider
	localparam int QDEPTH = 2;
	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	// divider sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIX
	} state_t;

	// request class found by the front end
	typedef struct packed {
		logic q_neg;
		logic r_neg;
		logic zero;
	} cls_t;

	localparam int CLS_W = $bits(cls_t);

endpackage

// ----- hdl/idv_front.sv -----
module idv_front import idv_pkg::*; #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                  op,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output logic [DATA_WIDTH-1:0] ua,
	output logic [DATA_WIDTH-1:0] ub,
	output cls_t                  cls
);

	logic a_neg;
	logic b_neg;

	// operand signs, only in signed mode
	assign a_neg = op & a[DATA_WIDTH-1];
	assign b_neg = op & b[DATA_WIDTH-1];

	// magnitudes
	assign ua = a_neg ? (~a + 1'b1) : a;
	assign ub = b_neg ? (~b + 1'b1) : b;

	// fix-up class for the back end
	always_comb begin
		cls.q_neg = a_neg ^ b_neg;
		cls.r_neg = a_neg;
		cls.zero  = (b == '0);
	end

endmodule

// ----- hdl/idv_queue.sv -----
module idv_queue import idv_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             nonempty,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign do_push  = push & ~full;
	assign do_pop   = pop & nonempty;
	assign rd_data  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- hdl/idv_back.sv -----
module idv_back import idv_pkg::*; #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic [DATA_WIDTH-1:0] req_ua,
	input  logic [DATA_WIDTH-1:0] req_ub,
	input  cls_t                  req_cls,
	output logic                  req_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_WIDTH-1:0] quot,
	output logic [DATA_WIDTH-1:0] rem,
	output logic                  zero
);

	localparam int STEP_W = $clog2(DATA_WIDTH);

	state_t                state_q;
	state_t                state_d;
	logic [DATA_WIDTH-1:0] n_q;
	logic [DATA_WIDTH-1:0] d_q;
	logic [DATA_WIDTH-1:0] part_q;
	logic [STEP_W-1:0]     step_q;
	cls_t                  cls_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] quot_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic                  zero_q;
	logic [DATA_WIDTH:0]   part_ext;
	logic [DATA_WIDTH+1:0] diff;
	logic                  ge;
	logic                  load;
	logic                  fire;
	logic                  taken;

	assign out_valid = out_valid_q;
	assign quot      = quot_q;
	assign rem       = rem_q;
	assign zero      = zero_q;
	assign taken     = out_valid_q & ~out_stall;

	// one restoring step: shift in next dividend bit, trial subtract
	assign part_ext = {part_q, n_q[DATA_WIDTH-1]};
	assign diff     = {1'b0, part_ext} - {2'b00, d_q};
	assign ge       = ~diff[DATA_WIDTH+1];

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		fire    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					load    = 1'b1;
					state_d = req_cls.zero ? ST_FIX : ST_RUN;
				end
			end
			ST_RUN: begin
				if (step_q == '0) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				if (!out_valid_q || !out_stall) begin
					fire    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign req_pop = load;

	// divider datapath, quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (load) begin
			n_q    <= req_ua;
			d_q    <= req_ub;
			part_q <= '0;
			step_q <= STEP_W'(DATA_WIDTH - 1);
			cls_q  <= req_cls;
		end else if (state_q == ST_RUN) begin
			n_q    <= {n_q[DATA_WIDTH-2:0], ge};
			part_q <= ge ? diff[DATA_WIDTH-1:0] : part_ext[DATA_WIDTH-1:0];
			step_q <= step_q - 1'b1;
		end
	end

	// sign fix-up into the output register
	always_ff @(posedge clk) begin
		if (fire) begin
			zero_q <= cls_q.zero;
			if (cls_q.zero) begin
				quot_q <= '0;
				rem_q  <= '0;
			end else begin
				quot_q <= cls_q.q_neg ? (~n_q + 1'b1) : n_q;
				rem_q  <= cls_q.r_neg ? (~part_q + 1'b1) : part_q;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (taken) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- hdl/int64_divider_signed_unsigned_unit.sv -----
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------
// in       | in_valid, in_stall    | op, dividend, divisor
// out      | out_valid, out_stall  | quotient, remainder, zero_divisor
//
// a request passes through a load step, then the shift-subtract loop at
// one quotient bit per cycle, then a sign fix-up step into the result register;
// a zero divisor skips the loop.
// the shift-subtract loop sets the rate; a two-entry queue in front of it
// takes new requests while it works, in_stall rises when that queue is full.
// the result register holds under out_stall while the next request runs.
// arst_n clears the queue, sequencer and output valid; no clearing pass.
module int64_divider_signed_unsigned_unit import idv_pkg::*; #(
	parameter int DATA_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [PORT_W-1:0] dividend,
	input  logic [PORT_W-1:0] divisor,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PORT_W-1:0] quotient,
	output logic [PORT_W-1:0] remainder,
	output logic              zero_divisor
);

	localparam int ENTRY_W = CLS_W + 2 * DATA_WIDTH;

	logic [DATA_WIDTH-1:0] f_ua;
	logic [DATA_WIDTH-1:0] f_ub;
	cls_t                  f_cls;
	logic [ENTRY_W-1:0]    wr_entry;
	logic [ENTRY_W-1:0]    rd_entry;
	logic                  q_full;
	logic                  q_nonempty;
	logic                  q_pop;
	cls_t                  b_cls;
	logic [DATA_WIDTH-1:0] b_ua;
	logic [DATA_WIDTH-1:0] b_ub;
	logic [DATA_WIDTH-1:0] quot_w;
	logic [DATA_WIDTH-1:0] rem_w;

	// classify and take magnitudes
	idv_front #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.op (op),
		.a  (dividend[DATA_WIDTH-1:0]),
		.b  (divisor[DATA_WIDTH-1:0]),
		.ua (f_ua),
		.ub (f_ub),
		.cls(f_cls)
	);

	assign wr_entry = {f_cls, f_ua, f_ub};
	assign in_stall = q_full;

	// request queue
	idv_queue #(
		.WIDTH(ENTRY_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (in_valid),
		.wr_data (wr_entry),
		.full    (q_full),
		.pop     (q_pop),
		.nonempty(q_nonempty),
		.rd_data (rd_entry)
	);

	assign b_cls = cls_t'(rd_entry[ENTRY_W-1 -: CLS_W]);
	assign b_ua  = rd_entry[2*DATA_WIDTH-1 -: DATA_WIDTH];
	assign b_ub  = rd_entry[DATA_WIDTH-1:0];

	// iterative divider and result register
	idv_back #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(q_nonempty),
		.req_ua   (b_ua),
		.req_ub   (b_ub),
		.req_cls  (b_cls),
		.req_pop  (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.quot     (quot_w),
		.rem      (rem_w),
		.zero     (zero_divisor)
	);

	assign quotient  = PORT_W'(quot_w);
	assign remainder = PORT_W'(rem_w);

endmodule

// ----- hdl/idv_checker.sv -----
module idv_checker import idv_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [PORT_W-1:0] quotient,
	input logic [PORT_W-1:0] remainder,
	input logic              zero_divisor
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its values
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(quotient) && $stable(remainder))
		else $error("result changed while stalled");

	// zero divisor gives zero quotient and remainder
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_divisor |-> quotient == '0 && remainder == '0)
		else $error("nonzero result on zero divisor");

	// reset empties queue and result register by the next edge
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("state not cleared in reset");

endmodule

bind int64_divider_signed_unsigned_unit idv_checker u_idv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.quotient    (quotient),
	.remainder   (remainder),
	.zero_divisor(zero_divisor)
);

// ----- test/idv_result_checker.sv -----
module idv_result_checker import idv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              op,
	input  logic [PORT_W-1:0] dividend,
	input  logic [PORT_W-1:0] divisor,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [PORT_W-1:0] quotient,
	input  logic [PORT_W-1:0] remainder,
	input  logic              zero_divisor,
	output int                mismatches,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [PORT_W-1:0] quotient;
		logic [PORT_W-1:0] remainder;
		logic              zero_divisor;
	} quot_rem_t;

	// results owed by the unit, oldest first
	quot_rem_t quot_rem_due[$];
	int        error_count;

	// truncating division on magnitudes, signs restored afterwards
	function automatic quot_rem_t divide_pair(input logic is_signed,
			input logic [PORT_W-1:0] num, input logic [PORT_W-1:0] den);
		logic              num_neg;
		logic              den_neg;
		logic [PORT_W-1:0] num_mag;
		logic [PORT_W-1:0] den_mag;
		quot_rem_t         res;
		num_neg = is_signed & num[PORT_W-1];
		den_neg = is_signed & den[PORT_W-1];
		num_mag = num_neg ? ~num + 1'b1 : num;
		den_mag = den_neg ? ~den + 1'b1 : den;
		res.quotient = '0;
		res.remainder = '0;
		res.zero_divisor = 1'b0;
		if (den_mag == '0) begin
			res.zero_divisor = 1'b1;
		end else begin
			res.quotient = num_mag / den_mag;
			res.remainder = num_mag % den_mag;
			// most negative over minus one wraps back to itself here
			if (num_neg != den_neg)
				res.quotient = ~res.quotient + 1'b1;
			if (num_neg)
				res.remainder = ~res.remainder + 1'b1;
		end
		return res;
	endfunction

	// compare delivered results first, then record the new request
	always @(posedge clk or negedge arst_n) begin
		quot_rem_t want;
		if (!arst_n) begin
			quot_rem_due.delete();
			error_count = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (quot_rem_due.size() == 0) begin
					$error("result with no request pending: quotient %h remainder %h",
						quotient, remainder);
					error_count++;
				end else begin
					want = quot_rem_due.pop_front();
					if (quotient !== want.quotient) begin
						$error("quotient mismatch: expected %h, actual %h",
							want.quotient, quotient);
						error_count++;
					end
					if (remainder !== want.remainder) begin
						$error("remainder mismatch: expected %h, actual %h",
							want.remainder, remainder);
						error_count++;
					end
					if (zero_divisor !== want.zero_divisor) begin
						$error("zero_divisor mismatch: expected %b, actual %b",
							want.zero_divisor, zero_divisor);
						error_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				quot_rem_due.push_back(divide_pair(op, dividend, divisor));
			mismatches <= error_count;
			outstanding <= quot_rem_due.size();
		end
	end

endmodule

// ----- test/tb_top.sv -----
module tb_top;
	import idv_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_PER_PHASE = 350;
	localparam int HOLD_LEN = 500;
	localparam logic OP_UNSIGNED = 1'b0;
	localparam logic OP_SIGNED = 1'b1;
	localparam logic [PORT_W-1:0] MOST_NEG = {1'b1, {(PORT_W-1){1'b0}}};
	localparam logic [PORT_W-1:0] MOST_POS = {1'b0, {(PORT_W-1){1'b1}}};
	localparam logic [PORT_W-1:0] ALL_ONES = '1;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              op;
	logic [PORT_W-1:0] dividend;
	logic [PORT_W-1:0] divisor;
	logic              out_valid;
	logic              out_stall;
	logic [PORT_W-1:0] quotient;
	logic [PORT_W-1:0] remainder;
	logic              zero_divisor;
	int                mismatches;
	int                outstanding;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_trigger = 0;

	int64_divider_signed_unsigned_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .dividend(dividend), .divisor(divisor),
		.out_valid(out_valid), .out_stall(out_stall),
		.quotient(quotient), .remainder(remainder), .zero_divisor(zero_divisor)
	);

	idv_result_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .dividend(dividend), .divisor(divisor),
		.out_valid(out_valid), .out_stall(out_stall),
		.quotient(quotient), .remainder(remainder), .zero_divisor(zero_divisor),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop
	initial begin
		#3ms;
		$display("Verification failed");
		$finish;
	end

	// result side: random stalls, long hold when asked
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_seen != hold_trigger) begin
				hold_seen = hold_trigger;
				hold_left = HOLD_LEN - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// one request, entered and left at a falling edge
	task automatic issue_division(input logic mode, input logic [PORT_W-1:0] num,
			input logic [PORT_W-1:0] den);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= mode;
		dividend <= num;
		divisor <= den;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// operand mix: full range, small magnitudes, powers of two, extremes
	function automatic logic [PORT_W-1:0] pick_operand();
		logic [PORT_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(7))
			0: v = PORT_W'($urandom_range(255));
			1: v = ~PORT_W'($urandom_range(255));
			2: v = PORT_W'(1) << $urandom_range(PORT_W - 1);
			3: v = v >> $urandom_range(PORT_W - 1);
			4: begin
				case ($urandom_range(4))
					0: v = '0;
					1: v = ALL_ONES;
					2: v = MOST_NEG;
					3: v = MOST_POS;
					default: v = PORT_W'(1);
				endcase
			end
			default: ;
		endcase
		return v;
	endfunction

	// stimulus and verdict
	initial begin
		logic [PORT_W-1:0] num;
		logic [PORT_W-1:0] den;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_UNSIGNED;
		dividend = '0;
		divisor = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, both modes, zero divisor, wrap case
		issue_division(OP_UNSIGNED, '0, PORT_W'(1));
		issue_division(OP_UNSIGNED, ALL_ONES, PORT_W'(1));
		issue_division(OP_UNSIGNED, ALL_ONES, ALL_ONES);
		issue_division(OP_UNSIGNED, PORT_W'(1), ALL_ONES);
		issue_division(OP_UNSIGNED, PORT_W'(100), PORT_W'(7));
		issue_division(OP_UNSIGNED, MOST_NEG, ALL_ONES);
		issue_division(OP_UNSIGNED, ALL_ONES, '0);
		issue_division(OP_UNSIGNED, '0, '0);
		issue_division(OP_UNSIGNED, ALL_ONES, MOST_POS);
		issue_division(OP_SIGNED, -PORT_W'(7), PORT_W'(2));
		issue_division(OP_SIGNED, PORT_W'(7), -PORT_W'(2));
		issue_division(OP_SIGNED, -PORT_W'(7), -PORT_W'(2));
		issue_division(OP_SIGNED, MOST_NEG, ALL_ONES);
		issue_division(OP_SIGNED, MOST_NEG, PORT_W'(1));
		issue_division(OP_SIGNED, MOST_POS, ALL_ONES);
		issue_division(OP_SIGNED, MOST_NEG, MOST_NEG);
		issue_division(OP_SIGNED, MOST_POS, MOST_NEG);
		issue_division(OP_SIGNED, PORT_W'(5), '0);
		issue_division(OP_SIGNED, ALL_ONES, '0);
		issue_division(OP_SIGNED, '0, ALL_ONES);
		issue_division(OP_SIGNED, MOST_NEG, MOST_POS);

		// random phases with different idle and stall pressure
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// long output hold so the input queue backs up
				if (phase == 0 && n == 50)
					hold_trigger++;
				num = pick_operand();
				case ($urandom_range(15))
					0: den = '0;
					1: den = num >> $urandom_range(PORT_W - 1);
					2: den = num;
					default: den = pick_operand();
				endcase
				issue_division($urandom_range(1) ? OP_SIGNED : OP_UNSIGNED, num, den);
			end
		end
		in_valid <= 1'b0;

		// drain
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/idv_pkg.sv
hdl/idv_front.sv
hdl/idv_queue.sv
hdl/idv_back.sv
hdl/int64_divider_signed_unsigned_unit.sv
hdl/idv_checker.sv
test/idv_result_checker.sv
test/tb_top.sv
